// File: src/fcr_pkg.sv
package fcr_pkg;

  localparam int FrameLen   = 8;
  localparam int PosW       = $clog2(FrameLen);
  localparam int TickWidth  = 24;
  localparam int LimitW     = 24;
  localparam int TailW      = 40;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 40;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] CrcPoly = 8'h07;

  localparam logic [7:0]        HeaderRst = 8'hAA;
  localparam logic [LimitW-1:0] LimitRst  = 24'd1000000;
  localparam logic [TailW-1:0]  TailRst   = 40'h0405060708;
  localparam logic [7:0]        CodeARst  = 8'd1;
  localparam logic [7:0]        CodeBRst  = 8'd2;
  localparam logic [7:0]        CodeWRst  = 8'd3;

  // action flag bit positions
  localparam int FlagLedA = 0;
  localparam int FlagLedB = 1;
  localparam int FlagWave = 2;

  typedef enum logic [1:0] {
    MATCH_NONE  = 2'd0,
    MATCH_LED_A = 2'd1,
    MATCH_LED_B = 2'd2,
    MATCH_WAVE  = 2'd3
  } match_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER    = 3'd0,
    CFG_LIMIT     = 3'd1,
    CFG_TAIL      = 3'd2,
    CFG_CODE_A    = 3'd3,
    CFG_CODE_B    = 3'd4,
    CFG_CODE_WAVE = 3'd5
  } cfg_idx_e;

  // classified beat handed from the front to the back
  typedef struct packed {
    logic       tick;
    logic       done;
    logic       good;
    match_e     match;
    logic [7:0] trim;
  } fcr_op_t;

  typedef struct packed {
    logic [7:0]       header;
    logic [TailW-1:0] tail;
    logic [7:0]       code_a;
    logic [7:0]       code_b;
    logic [7:0]       code_wave;
  } fcr_front_cfg_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: src/fcr_front.sv
module fcr_front import fcr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fcr_front_cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           command_i,
  input  logic [7:0]     data_byte_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output fcr_op_t        q_op_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      store_q [FrameLen-1];
  logic            store_we;
  logic [TailW-1:0] tail;
  logic            accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept;

  assign tail = {store_q[2], store_q[3], store_q[4], store_q[5], store_q[6]};

  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    store_we     = 1'b0;
    q_op_o       = '0;
    q_op_o.tick  = command_i;
    q_op_o.match = MATCH_NONE;
    q_op_o.trim  = store_q[FrameLen-2];
    if (accept && !command_i) begin
      if (pos_q == '0 && data_byte_i != cfg_i.header) begin
        // hunting: byte dropped
      end else if (pos_q != PosW'(FrameLen - 1)) begin
        store_we = 1'b1;
        crc_d    = crc8_byte(crc_q, data_byte_i);
        pos_d    = pos_q + 1'b1;
      end else begin
        q_op_o.done = 1'b1;
        q_op_o.good = (data_byte_i == crc_q);
        if (q_op_o.good && tail == cfg_i.tail) begin
          if (store_q[1] == cfg_i.code_a) begin
            q_op_o.match = MATCH_LED_A;
          end else if (store_q[1] == cfg_i.code_b) begin
            q_op_o.match = MATCH_LED_B;
          end else if (store_q[1] == cfg_i.code_wave) begin
            q_op_o.match = MATCH_WAVE;
          end
        end
        pos_d = '0;
        crc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[pos_q] <= data_byte_i;
    end
  end

endmodule

// File: src/fcr_queue.sv
module fcr_queue import fcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  fcr_op_t op_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output fcr_op_t op_o
);

  fcr_op_t           mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

// File: src/fcr_back.sv
module fcr_back import fcr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [LimitW-1:0] limit_i,
  input  logic              q_empty_i,
  input  fcr_op_t           q_op_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              frame_done_o,
  output logic              crc_good_o,
  output logic [1:0]        matched_cmd_o,
  output logic              led_a_on_o,
  output logic              led_b_on_o,
  output logic              wave_on_o,
  output logic [7:0]        trim_out_o,
  output logic              timed_out_o
);

  logic [TickWidth-1:0] ticks_q, ticks_d, ticks_inc;
  logic [2:0]           flags_q, flags_d;
  logic [7:0]           trim_q, trim_d;
  logic                 tout;
  logic                 valid_q;
  logic                 done_q, good_q, tout_q;
  logic [1:0]           match_q;

  assign q_pop_o = !q_empty_i && (!valid_q || out_ready_i);

  // saturating tick count
  assign ticks_inc = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;

  always_comb begin
    ticks_d = ticks_q;
    flags_d = flags_q;
    trim_d  = trim_q;
    tout    = 1'b0;
    if (q_pop_o) begin
      if (q_op_i.tick) begin
        if (32'(ticks_inc) >= 32'(limit_i)) begin
          tout    = 1'b1;
          flags_d = '0;
          ticks_d = '0;
        end else begin
          ticks_d = ticks_inc;
        end
      end else if (q_op_i.done) begin
        flags_d = '0;
        ticks_d = '0;
        case (q_op_i.match)
          MATCH_LED_A: flags_d[FlagLedA] = 1'b1;
          MATCH_LED_B: flags_d[FlagLedB] = 1'b1;
          MATCH_WAVE: begin
            flags_d[FlagWave] = 1'b1;
            trim_d            = q_op_i.trim;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      flags_q <= '0;
      trim_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      ticks_q <= ticks_d;
      flags_q <= flags_d;
      trim_q  <= trim_d;
      if (q_pop_o) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      done_q  <= q_op_i.done && !q_op_i.tick;
      good_q  <= q_op_i.good && q_op_i.done && !q_op_i.tick;
      match_q <= q_op_i.tick ? MATCH_NONE : q_op_i.match;
      tout_q  <= tout;
    end
  end

  assign out_valid_o   = valid_q;
  assign frame_done_o  = done_q;
  assign crc_good_o    = good_q;
  assign matched_cmd_o = match_q;
  // flags and trim only change on a pop, so they track the held result
  assign led_a_on_o    = flags_q[FlagLedA];
  assign led_b_on_o    = flags_q[FlagLedB];
  assign wave_on_o     = flags_q[FlagWave];
  assign trim_out_o    = trim_q;
  assign timed_out_o   = tout_q;

endmodule

// File: src/framed_command_receiver_crc8_core.sv
// Channel   Handshake              Payload
// in        in_valid_i/in_ready_o  command_i, data_byte_i
// out       out_valid_o/out_ready_i frame_done_o, crc_good_o, matched_cmd_o, led_a_on_o,
//                                  led_b_on_o, wave_on_o, trim_out_o, timed_out_o
// cfg       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle on each side while neither side is stalled. out_valid_o rises once the beat
// has passed through the queue entry and then the result register.
// The front does framing and CRC in the accept cycle, a 2-entry queue feeds the back,
// which updates the action flags and tick counter and holds the result register.
// in_ready_o drops only when the queue is full (output stalled).
// Reset loads the register defaults and clears position, CRC, counter and actions.
module framed_command_receiver_crc8_core import fcr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [7:0]          data_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                frame_done_o,
  output logic                crc_good_o,
  output logic [1:0]          matched_cmd_o,
  output logic                led_a_on_o,
  output logic                led_b_on_o,
  output logic                wave_on_o,
  output logic [7:0]          trim_out_o,
  output logic                timed_out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  fcr_front_cfg_t    fcfg_q;
  logic [LimitW-1:0] limit_q;
  logic              q_full, q_empty, q_push, q_pop;
  fcr_op_t           push_op, pop_op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcfg_q.header    <= HeaderRst;
      fcfg_q.tail      <= TailRst;
      fcfg_q.code_a    <= CodeARst;
      fcfg_q.code_b    <= CodeBRst;
      fcfg_q.code_wave <= CodeWRst;
      limit_q          <= LimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_HEADER:    fcfg_q.header    <= cfg_data_i[7:0];
        CFG_LIMIT:     limit_q          <= cfg_data_i[LimitW-1:0];
        CFG_TAIL:      fcfg_q.tail      <= cfg_data_i[TailW-1:0];
        CFG_CODE_A:    fcfg_q.code_a    <= cfg_data_i[7:0];
        CFG_CODE_B:    fcfg_q.code_b    <= cfg_data_i[7:0];
        CFG_CODE_WAVE: fcfg_q.code_wave <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  fcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (fcfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (push_op)
  );

  fcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (push_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (pop_op)
  );

  fcr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .limit_i       (limit_q),
    .q_empty_i     (q_empty),
    .q_op_i        (pop_op),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_done_o  (frame_done_o),
    .crc_good_o    (crc_good_o),
    .matched_cmd_o (matched_cmd_o),
    .led_a_on_o    (led_a_on_o),
    .led_b_on_o    (led_b_on_o),
    .wave_on_o     (wave_on_o),
    .trim_out_o    (trim_out_o),
    .timed_out_o   (timed_out_o)
  );

endmodule

// File: tb/fcr_tb_pkg.sv
`timescale 1ns / 100ps

package fcr_tb_pkg;
  import fcr_pkg::*;

  // register indexes past the last defined one; writes there must be dropped
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  typedef struct packed {
    logic       done;
    logic       good;
    match_e     match;
    logic       led_a;
    logic       led_b;
    logic       wave;
    logic [7:0] trim;
    logic       tout;
  } rx_result_t;

  // CRC-8 poly 0x07, MSB first, one byte folded in
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = {c[6:0], 1'b0} ^ (c[7] ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

endpackage

// File: tb/fcr_checker.sv
`timescale 1ns / 100ps

module fcr_checker import fcr_pkg::*; import fcr_tb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                command_i,
  input  logic [7:0]          data_byte_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                frame_done_i,
  input  logic                crc_good_i,
  input  logic [1:0]          matched_cmd_i,
  input  logic                led_a_on_i,
  input  logic                led_b_on_i,
  input  logic                wave_on_i,
  input  logic [7:0]          trim_out_i,
  input  logic                timed_out_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  results_seen_o,
  output int                  pending_o
);

  // register copies
  logic [7:0]        hdr_r;
  logic [LimitW-1:0] lim_r;
  logic [TailW-1:0]  tail_r;
  logic [7:0]        code_a_r, code_b_r, code_w_r;

  // receiver state
  logic [PosW-1:0]      pos;
  logic [7:0]           crc;
  logic [7:0]           frame_q [FrameLen-1];
  logic [TickWidth-1:0] idle_ticks;
  logic [2:0]           flags;
  logic [7:0]           trim;

  rx_result_t expected_results [$];
  int fails;
  int seen;

  function automatic rx_result_t decode_beat(input logic cmd, input logic [7:0] b);
    rx_result_t r;
    logic [TailW-1:0] got_tail;
    r = '0;
    if (cmd) begin
      if (idle_ticks != {TickWidth{1'b1}}) idle_ticks = idle_ticks + 1'b1;
      if (idle_ticks >= lim_r) begin
        r.tout = 1'b1;
        flags = '0;
        idle_ticks = '0;
      end
    end else if (pos == 0 && b != hdr_r) begin
      // hunting, byte dropped
    end else if (pos < FrameLen - 1) begin
      frame_q[pos] = b;
      crc = crc8_step(crc, b);
      pos = pos + 1'b1;
    end else begin
      r.done = 1'b1;
      r.good = (b == crc);
      flags = '0;
      if (r.good) begin
        got_tail = {frame_q[2], frame_q[3], frame_q[4], frame_q[5], frame_q[6]};
        if (got_tail == tail_r) begin
          if (frame_q[1] == code_a_r) begin
            r.match = MATCH_LED_A;
            flags[FlagLedA] = 1'b1;
          end else if (frame_q[1] == code_b_r) begin
            r.match = MATCH_LED_B;
            flags[FlagLedB] = 1'b1;
          end else if (frame_q[1] == code_w_r) begin
            r.match = MATCH_WAVE;
            flags[FlagWave] = 1'b1;
            trim = frame_q[FrameLen-2];
          end
        end
      end
      pos = '0;
      crc = '0;
      idle_ticks = '0;
    end
    r.led_a = flags[FlagLedA];
    r.led_b = flags[FlagLedB];
    r.wave  = flags[FlagWave];
    r.trim  = trim;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rx_result_t want;
    if (!rst_ni) begin
      hdr_r      = HeaderRst;
      lim_r      = LimitRst;
      tail_r     = TailRst;
      code_a_r   = CodeARst;
      code_b_r   = CodeBRst;
      code_w_r   = CodeWRst;
      pos        = '0;
      crc        = '0;
      idle_ticks = '0;
      flags      = '0;
      trim       = '0;
      foreach (frame_q[k]) frame_q[k] = '0;
      expected_results.delete();
      fails = 0;
      seen  = 0;
      fail_count_o   <= 0;
      results_seen_o <= 0;
      pending_o      <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HEADER:    hdr_r    = cfg_data_i[7:0];
          CFG_LIMIT:     lim_r    = cfg_data_i[LimitW-1:0];
          CFG_TAIL:      tail_r   = cfg_data_i[TailW-1:0];
          CFG_CODE_A:    code_a_r = cfg_data_i[7:0];
          CFG_CODE_B:    code_b_r = cfg_data_i[7:0];
          CFG_CODE_WAVE: code_w_r = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // retire before predicting: a result never belongs to the beat of this edge
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("frame_done",  want.done,  frame_done_i);
          check_field("crc_good",    want.good,  crc_good_i);
          check_field("matched_cmd", want.match, matched_cmd_i);
          check_field("led_a_on",    want.led_a, led_a_on_i);
          check_field("led_b_on",    want.led_b, led_b_on_i);
          check_field("wave_on",     want.wave,  wave_on_i);
          check_field("trim_out",    want.trim,  trim_out_i);
          check_field("timed_out",   want.tout,  timed_out_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(decode_beat(command_i, data_byte_i));
      end
      fail_count_o   <= fails;
      results_seen_o <= seen;
      pending_o      <= expected_results.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench import fcr_pkg::*, fcr_tb_pkg::*; ();

  localparam int NumPhases     = 8;
  localparam int PhaseItems    = 150;
  localparam int WatchdogLimit = 1000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic                in_command = 1'b0;
  logic [7:0]          in_data    = 8'h00;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic                res_done, res_good, res_led_a, res_led_b, res_wave, res_tout;
  logic [1:0]          res_match;
  logic [7:0]          res_trim;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  int fail_count, results_seen, pending;
  int items_sent  = 0;
  int ticks_sent  = 0;
  int frames_sent = 0;
  int cfg_writes  = 0;
  int burst_left  = 0;
  int gap_max     = 8;
  int quiet       = 0;

  // stimulus-side copy of the registers, used to build frames
  logic [7:0]       cur_hdr    = HeaderRst;
  logic [TailW-1:0] cur_tail   = TailRst;
  logic [7:0]       cur_code_a = CodeARst;
  logic [7:0]       cur_code_b = CodeBRst;
  logic [7:0]       cur_code_w = CodeWRst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  framed_command_receiver_crc8_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .command_i     (in_command),
    .data_byte_i   (in_data),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .frame_done_o  (res_done),
    .crc_good_o    (res_good),
    .matched_cmd_o (res_match),
    .led_a_on_o    (res_led_a),
    .led_b_on_o    (res_led_b),
    .wave_on_o     (res_wave),
    .trim_out_o    (res_trim),
    .timed_out_o   (res_tout),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  fcr_checker i_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .command_i      (in_command),
    .data_byte_i    (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .frame_done_i   (res_done),
    .crc_good_i     (res_good),
    .matched_cmd_i  (res_match),
    .led_a_on_i     (res_led_a),
    .led_b_on_i     (res_led_b),
    .wave_on_i      (res_wave),
    .trim_out_i     (res_trim),
    .timed_out_i    (res_tout),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .results_seen_o (results_seen),
    .pending_o      (pending)
  );

  // receiver backpressure: a randomly chosen stall mode drives out_ready
  logic [1:0] stall_mode = 2'd0;
  int mode_left = 0;
  int run_left  = 0;
  int pat_cnt   = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = 2'($urandom_range(0, 3));
      mode_left  = $urandom_range(64, 256);
    end
    mode_left--;
    pat_cnt++;
    case (stall_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (pat_cnt % 4 == 0);
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 12);
          out_ready <= ~out_ready;
        end
        run_left--;
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet == WatchdogLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic push_beat(input logic cmd, input logic [7:0] b);
    int gap;
    if (cfg_valid) cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_data    <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (cmd) ticks_sent++;
  endtask

  // only while idle: every beat sent has produced its result
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_seen != items_sent) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    case (cfg_idx_e'(idx))
      CFG_HEADER:    cur_hdr    = val[7:0];
      CFG_TAIL:      cur_tail   = val[TailW-1:0];
      CFG_CODE_A:    cur_code_a = val[7:0];
      CFG_CODE_B:    cur_code_b = val[7:0];
      CFG_CODE_WAVE: cur_code_w = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [7:0] hdr, input logic [LimitW-1:0] lim,
                         input logic [TailW-1:0] tail, input logic [7:0] ca,
                         input logic [7:0] cb, input logic [7:0] cw);
    write_reg(CFG_HEADER,    CfgDataW'(hdr));
    write_reg(CFG_LIMIT,     CfgDataW'(lim));
    write_reg(CFG_TAIL,      CfgDataW'(tail));
    write_reg(CFG_CODE_A,    CfgDataW'(ca));
    write_reg(CFG_CODE_B,    CfgDataW'(cb));
    write_reg(CFG_CODE_WAVE, CfgDataW'(cw));
  endtask

  // full 8-byte frame, ticks optionally sprinkled between its bytes
  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] code,
                            input logic [TailW-1:0] tail, input bit bad_crc,
                            input int tick_pct);
    logic [7:0] fb [FrameLen];
    logic [7:0] crc;
    crc   = 8'h00;
    fb[0] = hdr;
    fb[1] = code;
    for (int k = 0; k < FrameLen - 3; k++) fb[2+k] = tail[8*(FrameLen-4-k) +: 8];
    for (int k = 0; k < FrameLen - 1; k++) crc = crc8_step(crc, fb[k]);
    fb[FrameLen-1] = bad_crc ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc;
    frames_sent++;
    for (int k = 0; k < FrameLen; k++) begin
      if ($urandom_range(0, 99) < tick_pct) push_beat(1'b1, 8'($urandom()));
      push_beat(1'b0, fb[k]);
    end
  endtask

  initial begin
    int sel, ph_start, n;
    logic [7:0] h, ca, cb, cw, code;
    logic [LimitW-1:0] lim;
    logic [TailW-1:0] tl, flip;
    logic [63:0] r64;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, dropped byte, tick, LED A command
    push_beat(1'b0, 8'h00);
    push_beat(1'b1, 8'hFF);
    send_frame(cur_hdr, cur_code_a, cur_tail, 1'b0, 0);
    // extremes: zero header, all-ones tail, wave with trim 0xFF, limit of one tick
    set_all(8'h00, LimitW'(1), {TailW{1'b1}}, 8'hFF, 8'h00, 8'h80);
    send_frame(cur_hdr, cur_code_w, cur_tail, 1'b0, 0);
    push_beat(1'b1, 8'h00);
    // bad CRC on an otherwise matching LED B frame
    send_frame(cur_hdr, cur_code_b, cur_tail, 1'b1, 0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      gap_max = (ph % 3 == 2) ? 0 : 8;
      case ($urandom_range(0, 3))
        0: h = 8'h00;
        1: h = 8'hFF;
        default: h = 8'($urandom_range(0, 255));
      endcase
      if (ph == 0) begin
        lim = {LimitW{1'b1}};
      end else if (ph == 1) begin
        lim = LimitW'(1);
      end else begin
        case ($urandom_range(0, 5))
          0: lim = LimitW'(1);
          1: lim = LimitW'(2);
          2: lim = LimitW'($urandom_range(3, 12));
          3: lim = LimitW'($urandom_range(20, 80));
          4: lim = {LimitW{1'b1}};
          default: lim = LimitRst;
        endcase
      end
      r64 = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
        0: tl = '0;
        1: tl = '1;
        default: tl = r64[TailW-1:0];
      endcase
      ca = 8'($urandom_range(0, 255));
      cb = ($urandom_range(0, 3) == 0) ? ca : 8'($urandom_range(0, 255));
      cw = ($urandom_range(0, 3) == 0) ? cb : 8'($urandom_range(0, 255));
      set_all(h, lim, tl, ca, cb, cw);
      if (ph == NumPhases - 1) begin
        write_reg(CfgSpareLo, {$urandom(), 8'($urandom())});
        write_reg(CfgSpareHi, {$urandom(), 8'($urandom())});
      end

      ph_start = items_sent;
      while (items_sent - ph_start < PhaseItems) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          case ($urandom_range(0, 3))
            0: code = cur_code_a;
            1: code = cur_code_b;
            2: code = cur_code_w;
            default: code = 8'($urandom_range(0, 255));
          endcase
          tl = cur_tail;
          if ($urandom_range(0, 99) < 15) begin
            flip = '0;
            flip[$urandom_range(0, TailW-1)] = 1'b1;
            tl = tl ^ flip;
          end
          send_frame(cur_hdr, code, tl, $urandom_range(0, 9) == 0, 10);
        end else if (sel < 68) begin
          n = $urandom_range(1, 40);
          repeat (n) push_beat(1'b1, 8'($urandom()));
        end else if (sel < 84) begin
          push_beat(1'b0, 8'($urandom()));
        end else begin
          // truncated frame: later traffic completes it
          push_beat(1'b0, cur_hdr);
          n = $urandom_range(1, 6);
          repeat (n) push_beat(1'b0, 8'($urandom()));
        end
      end
    end

    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d beats (%0d ticks, %0d framed commands), %0d register writes,",
             items_sent, ticks_sent, frames_sent, cfg_writes);
    $display("%0d result beats compared over %0d register settings.",
             results_seen, NumPhases + 2);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
